// File: rtl/core/huffman_tree_load_and_decode_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman tree load and decode block
// Concurrent checks on i_clk, masked while i_rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_LOAD_AND_DECODE_ASSERT_SVH
`define HUFFMAN_TREE_LOAD_AND_DECODE_ASSERT_SVH

`ifndef SYNTHESIS

// expr must hold at every edge
`define HUFD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// cons must hold in the same cycle as ante
`define HUFD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define HUFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define HUFD_ASSERT_ALWAYS(label, expr, msg)
`define HUFD_ASSERT_IMPL(label, ante, cons, msg)
`define HUFD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/hufd_pkg.sv
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and codes of the Huffman tree load and decode block.
// ----------------------------------------------------------------------------
package hufd_pkg;

    localparam int MODE_W    = 2;
    localparam int VALUE_W   = 8;
    localparam int SYM_OUT_W = 8;

    // item kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_SHAPE  = 2'd0,
        MODE_SYMBOL = 2'd1,
        MODE_DATA   = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // one result beat
    typedef struct packed {
        logic [SYM_OUT_W-1:0] symbol;
        logic                 status;
    } t_res;

endpackage

// File: rtl/core/hufd_item_if.sv
// ----------------------------------------------------------------------------
// hufd_item_if
// Input channel: one beat carries a mode and a value byte.
// ----------------------------------------------------------------------------
interface hufd_item_if;

    logic                          valid;
    logic                          ready;
    logic [hufd_pkg::MODE_W-1:0]  mode;
    logic [hufd_pkg::VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);

endinterface

// File: rtl/core/hufd_res_if.sv
// ----------------------------------------------------------------------------
// hufd_res_if
// Result channel: one beat carries a decoded symbol and a status bit.
// ----------------------------------------------------------------------------
interface hufd_res_if;

    logic                            valid;
    logic                            ready;
    logic [hufd_pkg::SYM_OUT_W-1:0] symbol;
    logic                            status;

    modport source (output valid, output symbol, output status, input ready);
    modport sink   (input valid, input symbol, input status, output ready);

endinterface

// File: rtl/core/hufd_ram.sv
// ----------------------------------------------------------------------------
// hufd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hufd_ram #(
    parameter int  DEPTH = 2,
    parameter int  WIDTH = 1,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/hufd_res_fifo.sv
// ----------------------------------------------------------------------------
// hufd_res_fifo
// Two-entry result queue that decouples the decoder from the result sink.
// ----------------------------------------------------------------------------
module hufd_res_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hufd_pkg::t_res i_data,
    output logic [1:0]     o_count,
    hufd_res_if.source     o_res
);

    import hufd_pkg::*;

    t_res       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop = o_res.valid && o_res.ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    assign o_res.valid  = (r_count != 2'd0);
    assign o_res.symbol = r_slot[r_rd].symbol;
    assign o_res.status = r_slot[r_rd].status;
    assign o_count      = r_count;

endmodule

// File: rtl/core/huffman_tree_load_and_decode.sv
// A taken input beat reads the node memories, is executed from the read words,
// and its result beat is registered and then pushed into the result queue.
// No new beat is taken while one executes (the node memory read lies between
// taking a beat and updating the tree state) or while its result lacks room.
// Reset clears the counters, cursors and flags (root-only tree); node and
// symbol memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode
// Rebuilds a code tree from shape bits and leaf symbols held in node RAMs,
// then walks it with coded data bits and returns decoded symbols.
// ----------------------------------------------------------------------------
`include "huffman_tree_load_and_decode_assert.svh"

module huffman_tree_load_and_decode #(
    parameter int SYMBOL_BITS = 8,
    parameter int MAX_LEAVES  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hufd_item_if.sink   i_item,
    hufd_res_if.source  o_res
);

    import hufd_pkg::*;

    localparam int NODE_LIMIT = 2 * MAX_LEAVES - 1;
    localparam int NW = $clog2(NODE_LIMIT);       // node index
    localparam int CW = $clog2(NODE_LIMIT + 1);   // node count
    localparam int LW = $clog2(MAX_LEAVES);       // leaf ordinal
    localparam int KW = $clog2(MAX_LEAVES + 1);   // leaf count
    localparam int SW = SYMBOL_BITS;
    localparam int RW = NW + 1 + LW;              // {right link, leaf, ordinal}
    localparam int FW = 1 + LW;                   // {leaf, ordinal}

    // beat in execution
    logic               r_exec;
    t_mode              r_mode;
    logic [VALUE_W-1:0] r_val;

    // tree state
    logic [CW-1:0] r_nodes_used, n_nodes_used;
    logic [KW-1:0] r_leaves,     n_leaves;
    logic [KW-1:0] r_loaded,     n_loaded;
    logic [NW-1:0] r_build_cur,  n_build_cur;
    logic          r_prev_bit,   n_prev_bit;
    logic          r_shape_pos,  n_shape_pos;
    logic          r_complete,   n_complete;
    logic          r_root_leaf,  n_root_leaf;
    logic [NW-1:0] r_dec_cur,    n_dec_cur;

    // result stage
    logic r_res_vld;
    logic r_res_err;

    logic       w_accept;
    logic       w_room;
    logic       w_bit;
    logic       w_err;
    logic       w_lookup;
    logic [1:0] w_res_count;
    t_res       w_res_data;

    // memory ports
    logic          w_par_we;
    logic [NW-1:0] w_par_waddr, w_par_wdata, w_par_rdata;
    logic          w_leaf_we;
    logic [NW-1:0] w_leaf_waddr, w_leaf_raddr;
    logic [FW-1:0] w_leaf_wdata, w_leaf_rdata;
    logic          w_right_we;
    logic [NW-1:0] w_right_waddr;
    logic [RW-1:0] w_right_wdata, w_right_rdata;
    logic          w_sym_we;
    logic [LW-1:0] w_sym_waddr, w_sym_raddr;
    logic [SW-1:0] w_sym_wdata, w_sym_rdata;

    // derived values
    logic [NW-1:0] w_new_node;
    logic [NW-1:0] w_dec_next;
    logic          w_up_is_left;
    logic [LW-1:0] w_mark_ord;
    logic [NW-1:0] w_child;
    logic          w_child_leaf;
    logic [LW-1:0] w_child_ord;

    // handshake: one beat in execution at a time, room for its result
    assign w_room = (w_res_count == 2'd0) || ((w_res_count == 2'd1) && !r_res_vld);
    assign i_item.ready = !r_exec && w_room;
    assign w_accept     = i_item.valid && i_item.ready;

    assign w_bit        = r_val[0];
    assign w_new_node   = r_nodes_used[NW-1:0];
    assign w_dec_next   = r_dec_cur + 1'b1;
    assign w_leaf_raddr = (r_dec_cur == NW'(NODE_LIMIT - 1)) ? '0 : w_dec_next;
    assign w_up_is_left = (({1'b0, w_par_rdata} + (NW + 1)'(1)) == {1'b0, r_build_cur});
    assign w_mark_ord   = r_prev_bit ? r_leaves[LW-1:0] : '0;

    // left child of an inner node is always the next node index
    assign w_child      = w_bit ? w_right_rdata[RW-1 -: NW] : w_dec_next;
    assign w_child_leaf = w_bit ? w_right_rdata[LW] : w_leaf_rdata[LW];
    assign w_child_ord  = w_bit ? w_right_rdata[LW-1:0] : w_leaf_rdata[LW-1:0];

    // execute the beat with the node words read when it was taken
    always_comb begin
        n_nodes_used  = r_nodes_used;
        n_leaves      = r_leaves;
        n_loaded      = r_loaded;
        n_build_cur   = r_build_cur;
        n_prev_bit    = r_prev_bit;
        n_shape_pos   = r_shape_pos;
        n_complete    = r_complete;
        n_root_leaf   = r_root_leaf;
        n_dec_cur     = r_dec_cur;
        w_err         = 1'b0;
        w_lookup      = 1'b0;
        w_sym_raddr   = '0;
        w_par_we      = 1'b0;
        w_par_waddr   = w_new_node;
        w_par_wdata   = r_build_cur;
        w_leaf_we     = 1'b0;
        w_leaf_waddr  = w_new_node;
        w_leaf_wdata  = '0;
        w_right_we    = 1'b0;
        w_right_waddr = r_build_cur;
        w_right_wdata = '0;
        w_sym_we      = 1'b0;
        w_sym_waddr   = r_loaded[LW-1:0];
        w_sym_wdata   = SW'(r_val);
        if (r_exec) begin
            unique case (r_mode)
                MODE_SHAPE: begin
                    if (r_complete) begin
                        w_err = 1'b1;
                    end else if (w_bit) begin
                        if (r_nodes_used == CW'(NODE_LIMIT)) begin
                            w_err = 1'b1;
                        end else begin
                            // new node below the cursor
                            w_par_we     = 1'b1;
                            w_leaf_we    = 1'b1;
                            n_nodes_used = r_nodes_used + 1'b1;
                            n_build_cur  = w_new_node;
                            n_shape_pos  = 1'b1;
                            n_prev_bit   = 1'b1;
                            if (r_shape_pos && !r_prev_bit) begin
                                w_right_we    = 1'b1;
                                w_right_wdata = {w_new_node, 1'b0, LW'(0)};
                            end
                        end
                    end else if (!r_shape_pos) begin
                        // single leaf: root itself is the leaf
                        n_root_leaf = 1'b1;
                        n_leaves    = KW'(1);
                        n_complete  = 1'b1;
                        n_dec_cur   = '0;
                        n_shape_pos = 1'b1;
                        n_prev_bit  = 1'b0;
                    end else if (r_prev_bit && (r_leaves == KW'(MAX_LEAVES))) begin
                        w_err = 1'b1;
                    end else begin
                        if (r_prev_bit) begin
                            w_leaf_we    = 1'b1;
                            w_leaf_waddr = r_build_cur;
                            w_leaf_wdata = {1'b1, r_leaves[LW-1:0]};
                            n_leaves     = r_leaves + 1'b1;
                        end
                        if (r_build_cur == '0) begin
                            n_complete = 1'b1;
                            n_dec_cur  = '0;
                        end else begin
                            // climb; parent keeps a copy of its right child's leaf info
                            n_build_cur   = w_par_rdata;
                            w_right_we    = 1'b1;
                            w_right_waddr = w_par_rdata;
                            w_right_wdata = w_up_is_left ? '0
                                          : {r_build_cur, r_prev_bit, w_mark_ord};
                        end
                        n_shape_pos = 1'b1;
                        n_prev_bit  = 1'b0;
                    end
                end
                MODE_SYMBOL: begin
                    if (!r_complete || (r_loaded >= r_leaves)) begin
                        w_err = 1'b1;
                    end else begin
                        w_sym_we = 1'b1;
                        n_loaded = r_loaded + 1'b1;
                    end
                end
                MODE_DATA: begin
                    if (!r_complete || (r_loaded < r_leaves)) begin
                        w_err = 1'b1;
                    end else if (r_root_leaf) begin
                        w_lookup = 1'b1;
                    end else if (w_child == '0) begin
                        w_err     = 1'b1;
                        n_dec_cur = '0;
                    end else if (w_child_leaf) begin
                        w_lookup    = 1'b1;
                        w_sym_raddr = w_child_ord;
                        n_dec_cur   = '0;
                    end else begin
                        n_dec_cur = w_child;
                    end
                end
                MODE_CLEAR: begin
                    n_nodes_used = CW'(1);
                    n_leaves     = '0;
                    n_loaded     = '0;
                    n_build_cur  = '0;
                    n_prev_bit   = 1'b0;
                    n_shape_pos  = 1'b0;
                    n_complete   = 1'b0;
                    n_root_leaf  = 1'b0;
                    n_dec_cur    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // control and tree state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec       <= 1'b0;
            r_nodes_used <= CW'(1);
            r_leaves     <= '0;
            r_loaded     <= '0;
            r_build_cur  <= '0;
            r_prev_bit   <= 1'b0;
            r_shape_pos  <= 1'b0;
            r_complete   <= 1'b0;
            r_root_leaf  <= 1'b0;
            r_dec_cur    <= '0;
            r_res_vld    <= 1'b0;
        end else begin
            r_exec       <= w_accept;
            r_nodes_used <= n_nodes_used;
            r_leaves     <= n_leaves;
            r_loaded     <= n_loaded;
            r_build_cur  <= n_build_cur;
            r_prev_bit   <= n_prev_bit;
            r_shape_pos  <= n_shape_pos;
            r_complete   <= n_complete;
            r_root_leaf  <= n_root_leaf;
            r_dec_cur    <= n_dec_cur;
            r_res_vld    <= w_err || w_lookup;
        end
    end

    // beat payload and result kind
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= t_mode'(i_item.mode);
            r_val  <= i_item.value;
        end
        r_res_err <= w_err;
    end

    // node memories, read at the cursors (the leaf memory at the node after the decode cursor) when a beat is taken
    hufd_ram #(.DEPTH(NODE_LIMIT), .WIDTH(NW)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (w_par_we),
        .i_waddr (w_par_waddr),
        .i_wdata (w_par_wdata),
        .i_re    (w_accept),
        .i_raddr (r_build_cur),
        .o_rdata (w_par_rdata)
    );

    hufd_ram #(.DEPTH(NODE_LIMIT), .WIDTH(FW)) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (w_leaf_we),
        .i_waddr (w_leaf_waddr),
        .i_wdata (w_leaf_wdata),
        .i_re    (w_accept),
        .i_raddr (w_leaf_raddr),
        .o_rdata (w_leaf_rdata)
    );

    hufd_ram #(.DEPTH(NODE_LIMIT), .WIDTH(RW)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (w_right_we),
        .i_waddr (w_right_waddr),
        .i_wdata (w_right_wdata),
        .i_re    (w_accept),
        .i_raddr (r_dec_cur),
        .o_rdata (w_right_rdata)
    );

    // symbol table, looked up by leaf ordinal
    hufd_ram #(.DEPTH(MAX_LEAVES), .WIDTH(SW)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (w_sym_we),
        .i_waddr (w_sym_waddr),
        .i_wdata (w_sym_wdata),
        .i_re    (w_lookup),
        .i_raddr (w_sym_raddr),
        .o_rdata (w_sym_rdata)
    );

    // result beat: symbol from the table, zero on error
    assign w_res_data.symbol = r_res_err ? '0 : SYM_OUT_W'(w_sym_rdata);
    assign w_res_data.status = r_res_err ? STATUS_ERR : STATUS_OK;

    hufd_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_res_vld),
        .i_data  (w_res_data),
        .o_count (w_res_count),
        .o_res   (o_res)
    );

    // checks
    `HUFD_ASSERT_IMPL(a_fifo_room, r_res_vld, w_res_count != 2'd2, "result queue overflow")
    `HUFD_ASSERT_ALWAYS(a_cursor_in_tree, r_build_cur < r_nodes_used, "build cursor past nodes")
    `HUFD_ASSERT_ALWAYS(a_loaded_le_leaves, r_loaded <= r_leaves, "more symbols than leaves")
    `HUFD_ASSERT_IMPL(a_done_at_root, r_complete, r_build_cur == '0, "complete tree off root")
    `HUFD_ASSERT_NEXT(a_leaf_to_root, w_lookup, r_dec_cur == '0, "decode did not return to root")

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for huffman_tree_load_and_decode. Loads code trees of many
// shapes (single leaf, left-only chains, random and balanced trees of up to
// 40 leaves) with their leaf symbols, walks them with random coded bits, and
// mixes in misuse: items out of order, missing or extra symbols and clears
// in the middle of a load. A scoreboard predicts every result beat and
// checks the result channel in order while both sides of the handshake idle
// and stall at random.
// ----------------------------------------------------------------------------

// Tracks the tree the block should hold and the symbol beats it owes.
class symbol_scoreboard #(int LEAVES = 256);

    localparam int NODES = 2 * LEAVES - 1;

    // node memory, written as shape bits create nodes
    bit [8:0] left_link  [NODES];
    bit [8:0] right_link [NODES];
    bit [8:0] up_link    [NODES];
    bit       is_leaf    [NODES];
    bit [7:0] ordinal    [NODES];
    bit [7:0] sym_of_leaf[LEAVES];

    int unsigned node_count;
    int unsigned leaf_count;
    int unsigned sym_count;
    bit [8:0]    build_at;
    bit [8:0]    walk_at;
    bit          last_shape;
    bit          started;
    bit          complete;

    hufd_pkg::t_res pending_symbols[$];
    int             failures;

    function new();
        failures = 0;
        wipe();
    endfunction

    // back to a bare root
    function void wipe();
        left_link[0]  = '0;
        right_link[0] = '0;
        up_link[0]    = '0;
        is_leaf[0]    = 1'b0;
        ordinal[0]    = '0;
        node_count    = 1;
        leaf_count    = 0;
        sym_count     = 0;
        build_at      = '0;
        walk_at       = '0;
        last_shape    = 1'b0;
        started       = 1'b0;
        complete      = 1'b0;
    endfunction

    // one shape bit; returns 1 when it yields an error beat
    function bit shape_step(bit b);
        bit [8:0] here;
        int unsigned n;
        here = build_at;
        if (complete) return 1'b1;
        if (b) begin
            if (node_count >= NODES) return 1'b1;
            n = node_count;
            node_count++;
            left_link[n]  = '0;
            right_link[n] = '0;
            up_link[n]    = here;
            is_leaf[n]    = 1'b0;
            ordinal[n]    = '0;
            if (!started || last_shape) left_link[here] = 9'(n);
            else right_link[here] = 9'(n);
            build_at = 9'(n);
        end else if (!started) begin
            // lone zero: the root itself is the only leaf
            is_leaf[0] = 1'b1;
            ordinal[0] = '0;
            leaf_count = 1;
            complete   = 1'b1;
            walk_at    = '0;
        end else begin
            if (last_shape) begin
                if (leaf_count >= LEAVES) return 1'b1;
                is_leaf[here] = 1'b1;
                ordinal[here] = 8'(leaf_count);
                leaf_count++;
            end
            if (here == 0) begin
                complete = 1'b1;
                walk_at  = '0;
            end else begin
                build_at = up_link[here];
            end
        end
        started    = 1'b1;
        last_shape = b;
        return 1'b0;
    endfunction

    function bit symbol_step(bit [7:0] v);
        if (!complete || sym_count >= leaf_count || sym_count >= LEAVES) return 1'b1;
        sym_of_leaf[sym_count] = v;
        sym_count++;
        return 1'b0;
    endfunction

    // one coded bit; fills r when a symbol comes out
    function bit data_step(bit b, inout hufd_pkg::t_res r);
        bit [8:0] child;
        if (!complete || sym_count < leaf_count) return 1'b1;
        if (is_leaf[0]) begin
            r.symbol = sym_of_leaf[ordinal[0]];
            r.status = hufd_pkg::STATUS_OK;
            return 1'b1;
        end
        child = b ? right_link[walk_at] : left_link[walk_at];
        if (child == 0) begin
            walk_at = '0;
            return 1'b1;
        end
        if (is_leaf[child]) begin
            walk_at  = '0;
            r.symbol = sym_of_leaf[ordinal[child]];
            r.status = hufd_pkg::STATUS_OK;
            return 1'b1;
        end
        walk_at = child;
        return 1'b0;
    endfunction

    // accepted input beat
    function void take_item(hufd_pkg::t_mode m, bit [7:0] v);
        hufd_pkg::t_res r;
        bit has;
        r.symbol = '0;
        r.status = hufd_pkg::STATUS_ERR;
        case (m)
            hufd_pkg::MODE_SHAPE:  has = shape_step(v[0]);
            hufd_pkg::MODE_SYMBOL: has = symbol_step(v);
            hufd_pkg::MODE_DATA:   has = data_step(v[0], r);
            default: begin
                wipe();
                has = 1'b0;
            end
        endcase
        if (has) pending_symbols.push_back(r);
    endfunction

    function void note_failure(string msg);
        failures++;
        if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    // accepted result beat against the oldest expectation
    function void check_result(logic [7:0] sym, logic st);
        hufd_pkg::t_res want;
        if (pending_symbols.size() == 0) begin
            note_failure($sformatf("unexpected beat symbol=%02h status=%0b", sym, st));
            return;
        end
        want = pending_symbols.pop_front();
        if (sym !== want.symbol || st !== want.status)
            note_failure($sformatf("expected symbol=%02h status=%0b, got symbol=%02h status=%0b",
                                   want.symbol, want.status, sym, st));
    endfunction

endclass

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hufd_pkg::*;

    localparam int LEAF_CAP = 256;
    localparam int HOLD_OFF = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hufd_item_if item_bus ();
    hufd_res_if  res_bus ();

    huffman_tree_load_and_decode #(
        .SYMBOL_BITS (8),
        .MAX_LEAVES  (LEAF_CAP)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_res   (res_bus)
    );

    symbol_scoreboard #(LEAF_CAP) sb;

    bit calm;           // no idling on either side
    bit stall_req;      // ask the receiver for one long hold-off
    bit stall_pending;
    int items_sent;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random back-pressure plus one long hold-off
    initial begin : receiver
        int stall_left;
        stall_left    = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_bus.ready = 1'b0;
                stall_left--;
            end else if (stall_req) begin
                stall_req     = 1'b0;
                stall_left    = HOLD_OFF - 1;
                res_bus.ready = 1'b0;
            end else begin
                res_bus.ready = calm || ($urandom_range(99) >= 7);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            sb.check_result(res_bus.symbol, res_bus.status);
    end

    // one input beat; called at a falling edge, returns at a falling edge
    task automatic offer_beat(t_mode m, bit [7:0] v);
        while (!calm && $urandom_range(99) < 7) begin
            item_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        item_bus.valid = 1'b1;
        item_bus.mode  = m;
        item_bus.value = v;
        do @(posedge i_clk); while (!item_bus.ready);
        sb.take_item(m, v);
        items_sent++;
        @(negedge i_clk);
    endtask

    // serialized subtree: leaf is 1 0, inner node is 1 <left> <right> 0,
    // a node with only a left child is 1 <left> 0
    function automatic void grow_subtree(int leaves, bit unary_ok, bit even, ref bit bits[$]);
        int left_n;
        if (leaves == 1) begin
            bits.push_back(1'b1);
            if (unary_ok && $urandom_range(3) == 0) grow_subtree(1, unary_ok, even, bits);
            bits.push_back(1'b0);
            return;
        end
        bits.push_back(1'b1);
        left_n = even ? leaves / 2 : $urandom_range(leaves - 1, 1);
        grow_subtree(left_n, unary_ok, even, bits);
        grow_subtree(leaves - left_n, unary_ok, even, bits);
        bits.push_back(1'b0);
    endfunction

    // load a tree, its symbols and some coded bits, with an optional flaw
    task automatic decode_round(int leaves);
        bit shape[$];
        bit even;
        int flaw;
        int left_n;
        int sym_n;
        int n_data;
        int cut;
        flaw = $urandom_range(11);
        even = ($urandom_range(3) == 0);
        if (leaves == 1 && $urandom_range(1)) begin
            shape.push_back(1'b0);
        end else if (leaves == 1 || $urandom_range(4) == 0) begin
            grow_subtree(leaves, !even, even, shape);
            shape.push_back(1'b0);
        end else begin
            left_n = even ? leaves / 2 : $urandom_range(leaves - 1, 1);
            grow_subtree(left_n, !even, even, shape);
            grow_subtree(leaves - left_n, !even, even, shape);
            shape.push_back(1'b0);
        end
        cut = $urandom_range(shape.size() - 1);

        foreach (shape[i]) begin
            if (i == cut && flaw == 0) offer_beat(MODE_SYMBOL, 8'($urandom));
            if (i == cut && flaw == 1) offer_beat(MODE_DATA, 8'($urandom));
            if (i == cut && flaw == 2) begin
                offer_beat(MODE_CLEAR, 8'($urandom));
                return;
            end
            if (flaw == 3 && $urandom_range(9) == 0)
                offer_beat(t_mode'($urandom_range(2)), 8'($urandom));
            offer_beat(MODE_SHAPE, {7'($urandom_range(127)), shape[i]});
        end
        if (flaw == 4) offer_beat(MODE_SHAPE, 8'($urandom));
        if (flaw == 5) offer_beat(MODE_DATA, 8'($urandom));

        sym_n = leaves;
        if (flaw == 6) sym_n = leaves - 1;
        if (flaw == 7) sym_n = leaves + 1;
        repeat (sym_n) offer_beat(MODE_SYMBOL, 8'($urandom));

        n_data = $urandom_range(40, 4);
        if (stall_pending && n_data >= 20) begin
            stall_pending = 1'b0;
            stall_req     = 1'b1;
        end
        repeat (n_data) offer_beat(MODE_DATA, 8'($urandom));
        if (flaw == 6) begin
            // the late symbol unlocks decoding
            offer_beat(MODE_SYMBOL, 8'($urandom));
            repeat (6) offer_beat(MODE_DATA, 8'($urandom));
        end
        offer_beat(MODE_CLEAR, 8'($urandom));
    endtask

    // stimulus and end of run
    initial begin : stimulus
        int drain;
        int calm_end;
        int random_end;
        sb             = new();
        calm           = 1'b0;
        stall_req      = 1'b0;
        stall_pending  = 1'b1;
        items_sent     = 0;
        item_bus.valid = 1'b0;
        item_bus.mode  = MODE_SHAPE;
        item_bus.value = '0;
        i_rst_n        = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // misuse on an empty tree, then a single-leaf tree
        offer_beat(MODE_DATA, 8'h01);
        offer_beat(MODE_SYMBOL, 8'hAA);
        offer_beat(MODE_SHAPE, 8'hFE);
        offer_beat(MODE_SHAPE, 8'h01);
        offer_beat(MODE_DATA, 8'h00);
        offer_beat(MODE_SYMBOL, 8'hFF);
        offer_beat(MODE_SYMBOL, 8'h00);
        offer_beat(MODE_DATA, 8'hFE);
        offer_beat(MODE_DATA, 8'h01);
        offer_beat(MODE_CLEAR, 8'hFF);
        // left-only chain: root -> a -> leaf; right steps hit missing children
        offer_beat(MODE_SHAPE, 8'h01);
        offer_beat(MODE_SHAPE, 8'hFF);
        offer_beat(MODE_SHAPE, 8'h00);
        offer_beat(MODE_SHAPE, 8'hFE);
        offer_beat(MODE_SHAPE, 8'h80);
        offer_beat(MODE_SYMBOL, 8'h00);
        offer_beat(MODE_DATA, 8'h00);
        offer_beat(MODE_DATA, 8'hFE);
        offer_beat(MODE_DATA, 8'h01);
        offer_beat(MODE_DATA, 8'h00);
        offer_beat(MODE_DATA, 8'hFF);
        offer_beat(MODE_CLEAR, 8'h00);
        // two leaves
        offer_beat(MODE_SHAPE, 8'h01);
        offer_beat(MODE_SHAPE, 8'h00);
        offer_beat(MODE_SHAPE, 8'h01);
        offer_beat(MODE_SHAPE, 8'h00);
        offer_beat(MODE_SHAPE, 8'h00);
        offer_beat(MODE_SYMBOL, 8'h55);
        offer_beat(MODE_SYMBOL, 8'h80);
        offer_beat(MODE_DATA, 8'h00);
        offer_beat(MODE_DATA, 8'hFF);
        offer_beat(MODE_CLEAR, 8'h5A);

        // a stretch with no idling on either side
        calm     = 1'b1;
        calm_end = items_sent + 80;
        while (items_sent < calm_end)
            decode_round($urandom_range(8, 1));
        calm = 1'b0;

        random_end = items_sent + 300;
        while (items_sent < random_end)
            decode_round(($urandom_range(9) == 0) ? $urandom_range(40, 9)
                                                  : $urandom_range(8, 1));
        item_bus.valid = 1'b0;

        drain = 0;
        while (sb.pending_symbols.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);

        if (sb.pending_symbols.size() != 0)
            $display("mismatch: %0d expected beats never arrived", sb.pending_symbols.size());
        if (sb.failures == 0 && sb.pending_symbols.size() == 0) begin
            $display("[huffman_tree_load_and_decode] OK");
        end else begin
            $display("[huffman_tree_load_and_decode] ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #3_000_000;
        $display("[huffman_tree_load_and_decode] ERROR");
        $finish;
    end

endmodule
